[rtl/bitmap_page_allocator_macros.svh]
// Assertion macros for the bitmap page allocator.
// Included by the controller and the datapath; depends on nothing else.
`ifndef BITMAP_PAGE_ALLOCATOR_MACROS_SVH
`define BITMAP_PAGE_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
// A property that must hold at every clock edge outside reset.
`define BPA_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("bitmap page allocator check failed");
// An implication checked at every clock edge outside reset.
`define BPA_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bitmap page allocator check failed");
`else
`define BPA_ASSERT(lbl, prop)
`define BPA_ASSERT_IMPLY(lbl, ante, cons)
`endif
`endif

[rtl/bpa_pkg.sv]
// Shared constants, payload structs and controller/datapath command types
// for the bitmap page allocator. Depends on nothing.
`default_nettype none

package bpa_pkg;

    localparam int MAX_PAGES  = 4096;
    localparam int PAGE_SHIFT = 12;
    localparam int WORD_BITS  = 64;
    localparam int NUM_WORDS  = MAX_PAGES / WORD_BITS;
    localparam int WIDX_W     = $clog2(NUM_WORDS);
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int PIDX_W     = $clog2(MAX_PAGES);
    localparam int CNT_W      = 13;
    localparam int ADDR_W     = 48;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POOL_PAGES = 1'd1;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_BAD_ADDR = 2'd2;
    localparam logic [1:0] ST_DUP_FREE = 2'd3;

    typedef struct packed {
        logic              opcode;
        logic [CNT_W-1:0]  page_count;
        logic [ADDR_W-1:0] address;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] result_address;
        logic [CNT_W-1:0]  already_free_count;
    } rsp_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_PREP,
        DP_RESCAN,
        DP_SCAN,
        DP_MARK_RD,
        DP_MARK_WR,
        DP_CLR_RD,
        DP_CLR_WR,
        DP_CLR_ACC,
        DP_EMIT
    } dp_op_t;

    typedef enum logic [1:0] {
        RES_ALLOC_OK,
        RES_NO_SPACE,
        RES_BAD_ADDR,
        RES_FREE_DONE
    } res_kind_t;

    typedef struct packed {
        dp_op_t    op;
        res_kind_t kind;
    } dp_cmd_t;

    typedef struct packed {
        logic is_free;
        logic fits;
        logic in_range;
        logic has_clear;
        logic hint_zero;
        logic scan_found;
        logic scan_miss;
        logic word_last;
        logic out_busy;
    } dp_status_t;

endpackage

`default_nettype wire

[rtl/bpa_ctrl.sv]
// Sequencing state machine of the bitmap page allocator.
// Uses bpa_pkg and the assertion macros header.
`default_nettype none
`include "bitmap_page_allocator_macros.svh"

module bpa_ctrl
    import bpa_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  dp_status_t      status,
    output dp_cmd_t         cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN1,
        S_RESCAN,
        S_SCAN2,
        S_MARK_RD,
        S_MARK_WR,
        S_CLR_RD,
        S_CLR_WR,
        S_CLR_ACC,
        S_FINISH
    } state_t;

    state_t    state_reg, state_next;
    res_kind_t kind_reg, kind_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        cmd.op     = DP_NOP;
        cmd.kind   = kind_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = DP_LOAD;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.op = DP_PREP;
                if (status.is_free)
                begin
                    if (!status.in_range)
                    begin
                        kind_next  = RES_BAD_ADDR;
                        state_next = S_FINISH;
                    end
                    else if (status.has_clear)
                    begin
                        state_next = S_CLR_RD;
                    end
                    else
                    begin
                        kind_next  = RES_FREE_DONE;
                        state_next = S_FINISH;
                    end
                end
                else if (!status.fits)
                begin
                    kind_next  = RES_NO_SPACE;
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_SCAN1;
                end
            end
            S_SCAN1:
            begin
                cmd.op = DP_SCAN;
                if (status.scan_found)
                begin
                    state_next = S_MARK_RD;
                end
                else if (status.scan_miss)
                begin
                    if (status.hint_zero)
                    begin
                        kind_next  = RES_NO_SPACE;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_RESCAN;
                    end
                end
            end
            S_RESCAN:
            begin
                cmd.op     = DP_RESCAN;
                state_next = S_SCAN2;
            end
            S_SCAN2:
            begin
                cmd.op = DP_SCAN;
                if (status.scan_found)
                begin
                    state_next = S_MARK_RD;
                end
                else if (status.scan_miss)
                begin
                    kind_next  = RES_NO_SPACE;
                    state_next = S_FINISH;
                end
            end
            S_MARK_RD:
            begin
                cmd.op     = DP_MARK_RD;
                state_next = S_MARK_WR;
            end
            S_MARK_WR:
            begin
                cmd.op = DP_MARK_WR;
                if (status.word_last)
                begin
                    kind_next  = RES_ALLOC_OK;
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_MARK_RD;
                end
            end
            S_CLR_RD:
            begin
                cmd.op     = DP_CLR_RD;
                state_next = S_CLR_WR;
            end
            S_CLR_WR:
            begin
                cmd.op     = DP_CLR_WR;
                state_next = S_CLR_ACC;
            end
            S_CLR_ACC:
            begin
                cmd.op = DP_CLR_ACC;
                if (status.word_last)
                begin
                    kind_next  = RES_FREE_DONE;
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_CLR_RD;
                end
            end
            S_FINISH:
            begin
                if (!status.out_busy)
                begin
                    cmd.op     = DP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            kind_reg  <= RES_NO_SPACE;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    // A write-back always follows the read of the same word.
    `BPA_ASSERT_IMPLY(a_mark_after_read, cmd.op == DP_MARK_WR, $past(cmd.op) == DP_MARK_RD)
    // Once a result has been handed over the next request may be taken.
    `BPA_ASSERT_IMPLY(a_idle_after_emit, cmd.op == DP_EMIT, ##1 in_ready)
    // A free request never starts a bitmap search.
    `BPA_ASSERT_IMPLY(a_no_scan_on_free, cmd.op == DP_SCAN, !status.is_free)

endmodule

`default_nettype wire

[rtl/bpa_datapath.sv]
// Datapath of the bitmap page allocator: bitmap memory, search pipeline,
// counters and the result register. Uses bpa_pkg and the assertion macros.
`default_nettype none
`include "bitmap_page_allocator_macros.svh"

module bpa_datapath
    import bpa_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  req_t                       in_data,
    input  dp_cmd_t                    cmd,
    output dp_status_t                 status,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output rsp_t                       out_data
);

    localparam logic [WORD_BITS-1:0] ONES = '1;
    localparam int NPOW = BIT_W + 1;

    // Configuration and request registers.
    logic [ADDR_W-1:0] base_reg;
    logic [CNT_W-1:0]  eff_reg;
    logic              op_reg;
    logic [CNT_W-1:0]  n_reg;
    logic [ADDR_W-1:0] addr_reg;

    // Allocator state.
    logic [CNT_W-1:0]     free_reg;
    logic [PIDX_W-1:0]    hint_reg;
    logic [NUM_WORDS-1:0] wvalid_reg;
    logic [WORD_BITS-1:0] mem [NUM_WORDS];

    // Region walk for marking and clearing.
    logic [PIDX_W-1:0] rg_first_reg, rg_last_reg;
    logic [WIDX_W-1:0] ptr_reg;
    logic [CNT_W-1:0]  span_reg, freed_reg;
    logic [BIT_W:0]    pop_lo_reg, pop_hi_reg;

    // Search pipeline.
    logic [WIDX_W-1:0]    sw_reg;
    logic                 issue_on_reg, first_pend_reg;
    logic [BIT_W-1:0]     from_bit_reg;
    logic                 found_reg, miss_reg;
    logic [PIDX_W-1:0]    at_reg;
    logic [CNT_W-1:0]     run_reg, run_start_reg;
    logic                 s1_v_reg, s1_first_reg, s1_last_reg;
    logic [WIDX_W-1:0]    s1_w_reg;
    logic                 s2_v_reg, s2_last_reg;
    logic [WIDX_W-1:0]    s2_w_reg;
    logic [WORD_BITS-1:0] s2_f_reg;
    logic                 s3_v_reg, s3_last_reg, s3_all_reg;
    logic [WIDX_W-1:0]    s3_w_reg;
    logic [BIT_W:0]       s3_t_reg, s3_lead_reg;
    logic [WORD_BITS-1:0] s3_a_reg [NPOW];
    logic                 s4_v_reg, s4_last_reg, s4_all_reg, s4_any_reg;
    logic [WIDX_W-1:0]    s4_w_reg;
    logic [BIT_W:0]       s4_t_reg, s4_lead_reg;
    logic [BIT_W-1:0]     s4_p_reg;

    logic [WORD_BITS-1:0] rd_data_reg;
    logic                 rd_ok_reg;

    logic                 out_valid_reg;
    rsp_t                 out_data_reg;

    // Combinational signals.
    logic [PIDX_W-1:0]    hint_eff, last_pg, from_pg, idx;
    logic [ADDR_W-1:0]    diff;
    logic [ADDR_W:0]      pool_end;
    logic                 in_range;
    logic [PIDX_W+1:0]    clr_sum, clr_end;
    logic [WIDX_W-1:0]    rd_addr;
    logic [WORD_BITS-1:0] word_in, rmask, mask2, a_next [NPOW], win;
    logic [BIT_W-1:0]     lo_bit, hi_bit, p_next;
    logic                 any_next, scan_issue;
    logic [BIT_W:0]       t_next, lead_next, off;
    logic                 comb_en, comb_hit_a, comb_hit_b;
    logic [CNT_W:0]       run_sum;
    logic [PIDX_W-1:0]    comb_at;
    logic [CNT_W-1:0]     dup;

    assign hint_eff = ({1'b0, hint_reg} < eff_reg) ? hint_reg : '0;
    assign last_pg  = PIDX_W'(eff_reg - CNT_W'(1));
    assign from_pg  = (cmd.op == DP_RESCAN) ? '0 : hint_eff;
    assign diff     = addr_reg - base_reg;
    assign idx      = diff[PAGE_SHIFT +: PIDX_W];
    assign pool_end = {1'b0, base_reg} + ((ADDR_W+1)'(eff_reg) << PAGE_SHIFT);
    assign in_range = (addr_reg >= base_reg) && ({1'b0, addr_reg} < pool_end);
    assign clr_sum  = (PIDX_W+2)'(idx) + (PIDX_W+2)'(n_reg);
    assign clr_end  = (clr_sum > (PIDX_W+2)'(eff_reg)) ? (PIDX_W+2)'(eff_reg) : clr_sum;

    assign scan_issue = (cmd.op == DP_SCAN) && issue_on_reg && !found_reg;
    assign rd_addr    = scan_issue ? sw_reg : ptr_reg;
    assign word_in    = rd_ok_reg ? rd_data_reg : '0;

    assign lo_bit = (ptr_reg == rg_first_reg[PIDX_W-1 -: WIDX_W]) ? rg_first_reg[BIT_W-1:0] : '0;
    assign hi_bit = (ptr_reg == rg_last_reg[PIDX_W-1 -: WIDX_W]) ? rg_last_reg[BIT_W-1:0] : '1;
    assign rmask  = (ONES << lo_bit) & (ONES >> (BIT_W'(WORD_BITS-1) - hi_bit));

    // Stage two input: free pages of the word, with pages before the search start
    // and past the pool end treated as used.
    assign mask2 = (s1_first_reg ? (ONES << from_bit_reg) : ONES)
                 & (s1_last_reg ? (ONES >> (BIT_W'(WORD_BITS-1) - last_pg[BIT_W-1:0])) : ONES);

    // Runs of free pages of length 2**k starting at each bit, and the edge runs.
    always_comb
    begin
        a_next[0] = s2_f_reg;
        for (int k = 1; k < NPOW; k++)
        begin
            a_next[k] = a_next[k-1] & (a_next[k-1] >> (1 << (k-1)));
        end
        t_next = (BIT_W+1)'(WORD_BITS);
        for (int i = WORD_BITS-1; i >= 0; i--)
        begin
            if (!s2_f_reg[i])
            begin
                t_next = (BIT_W+1)'(i);
            end
        end
        lead_next = (BIT_W+1)'(WORD_BITS);
        for (int i = 0; i < WORD_BITS; i++)
        begin
            if (!s2_f_reg[i])
            begin
                lead_next = (BIT_W+1)'(WORD_BITS-1-i);
            end
        end
    end

    // Windows of n free pages inside the word, from the power-of-two runs.
    always_comb
    begin
        win = ONES;
        for (int k = 0; k < NPOW; k++)
        begin
            off = n_reg[BIT_W:0] & (BIT_W+1)'((1 << k) - 1);
            if (n_reg[k])
            begin
                win = win & (s3_a_reg[k] >> off);
            end
        end
        any_next = (n_reg <= CNT_W'(WORD_BITS)) && (win != '0);
        p_next   = '0;
        for (int i = WORD_BITS-1; i >= 0; i--)
        begin
            if (win[i])
            begin
                p_next = BIT_W'(i);
            end
        end
    end

    // Joining the word with the free run carried in from the words before it.
    assign comb_en    = s4_v_reg && !found_reg && !miss_reg;
    assign run_sum    = (CNT_W+1)'(run_reg) + (CNT_W+1)'(s4_t_reg);
    assign comb_hit_a = run_sum >= (CNT_W+1)'(n_reg);
    assign comb_hit_b = s4_any_reg;
    assign comb_at    = comb_hit_a ? run_start_reg[PIDX_W-1:0] : {s4_w_reg, s4_p_reg};

    assign dup = span_reg - freed_reg;

    assign status.is_free    = (op_reg == OP_FREE);
    assign status.fits       = (n_reg <= free_reg) && (n_reg <= eff_reg);
    assign status.in_range   = in_range;
    assign status.has_clear  = (n_reg != '0);
    assign status.hint_zero  = (hint_eff == '0);
    assign status.scan_found = found_reg;
    assign status.scan_miss  = miss_reg;
    assign status.word_last  = (ptr_reg == rg_last_reg[PIDX_W-1 -: WIDX_W]);
    assign status.out_busy   = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Bitmap memory: one registered read and one write port.
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
        if (cmd.op == DP_MARK_WR)
        begin
            mem[ptr_reg] <= word_in | rmask;
        end
        else if (cmd.op == DP_CLR_WR)
        begin
            mem[ptr_reg] <= word_in & ~rmask;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.op == DP_LOAD)
        begin
            op_reg   <= in_data.opcode;
            n_reg    <= (in_data.opcode == OP_ALLOC && in_data.page_count == '0)
                        ? CNT_W'(1) : in_data.page_count;
            addr_reg <= in_data.address;
        end
        if (cmd.op == DP_CLR_WR)
        begin
            pop_lo_reg <= (BIT_W+1)'($countones(word_in[WORD_BITS/2-1:0] & rmask[WORD_BITS/2-1:0]));
            pop_hi_reg <= (BIT_W+1)'($countones(word_in[WORD_BITS-1:WORD_BITS/2]
                                                & rmask[WORD_BITS-1:WORD_BITS/2]));
        end
        s1_w_reg     <= sw_reg;
        s1_first_reg <= first_pend_reg;
        s1_last_reg  <= (sw_reg == last_pg[PIDX_W-1 -: WIDX_W]);
        s2_w_reg     <= s1_w_reg;
        s2_last_reg  <= s1_last_reg;
        s2_f_reg     <= ~word_in & mask2;
        s3_w_reg     <= s2_w_reg;
        s3_last_reg  <= s2_last_reg;
        s3_all_reg   <= (s2_f_reg == ONES);
        s3_t_reg     <= t_next;
        s3_lead_reg  <= lead_next;
        for (int k = 0; k < NPOW; k++)
        begin
            s3_a_reg[k] <= a_next[k];
        end
        s4_w_reg    <= s3_w_reg;
        s4_last_reg <= s3_last_reg;
        s4_all_reg  <= s3_all_reg;
        s4_t_reg    <= s3_t_reg;
        s4_lead_reg <= s3_lead_reg;
        s4_any_reg  <= any_next;
        s4_p_reg    <= p_next;
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg       <= '0;
            eff_reg        <= '0;
            free_reg       <= '0;
            hint_reg       <= '0;
            wvalid_reg     <= '0;
            rd_ok_reg      <= 1'b0;
            rg_first_reg   <= '0;
            rg_last_reg    <= '0;
            ptr_reg        <= '0;
            span_reg       <= '0;
            freed_reg      <= '0;
            sw_reg         <= '0;
            issue_on_reg   <= 1'b0;
            first_pend_reg <= 1'b0;
            from_bit_reg   <= '0;
            found_reg      <= 1'b0;
            miss_reg       <= 1'b0;
            at_reg         <= '0;
            run_reg        <= '0;
            run_start_reg  <= '0;
            s1_v_reg       <= 1'b0;
            s2_v_reg       <= 1'b0;
            s3_v_reg       <= 1'b0;
            s4_v_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
        end
        else
        begin
            rd_ok_reg <= wvalid_reg[rd_addr];
            s1_v_reg  <= scan_issue;
            s2_v_reg  <= s1_v_reg;
            s3_v_reg  <= s2_v_reg;
            s4_v_reg  <= s3_v_reg;

            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_POOL_BASE:
                    begin
                        base_reg <= cfg_data[ADDR_W-1:0];
                    end
                    REG_POOL_PAGES:
                    begin
                        eff_reg    <= (cfg_data[CNT_W-1:0] > CNT_W'(MAX_PAGES))
                                      ? CNT_W'(MAX_PAGES) : cfg_data[CNT_W-1:0];
                        free_reg   <= (cfg_data[CNT_W-1:0] > CNT_W'(MAX_PAGES))
                                      ? CNT_W'(MAX_PAGES) : cfg_data[CNT_W-1:0];
                        hint_reg   <= '0;
                        wvalid_reg <= '0;
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (cmd.op == DP_PREP || cmd.op == DP_RESCAN)
            begin
                sw_reg         <= from_pg[PIDX_W-1 -: WIDX_W];
                from_bit_reg   <= from_pg[BIT_W-1:0];
                issue_on_reg   <= 1'b1;
                first_pend_reg <= 1'b1;
                found_reg      <= 1'b0;
                miss_reg       <= 1'b0;
                run_reg        <= '0;
                run_start_reg  <= CNT_W'(from_pg);
                s1_v_reg       <= 1'b0;
                s2_v_reg       <= 1'b0;
                s3_v_reg       <= 1'b0;
                s4_v_reg       <= 1'b0;
            end
            if (cmd.op == DP_PREP)
            begin
                rg_first_reg <= idx;
                rg_last_reg  <= PIDX_W'(clr_end - (PIDX_W+2)'(1));
                ptr_reg      <= idx[PIDX_W-1 -: WIDX_W];
                span_reg     <= CNT_W'(clr_end - (PIDX_W+2)'(idx));
                freed_reg    <= '0;
            end

            if (scan_issue)
            begin
                first_pend_reg <= 1'b0;
                if (sw_reg == last_pg[PIDX_W-1 -: WIDX_W])
                begin
                    issue_on_reg <= 1'b0;
                end
                else
                begin
                    sw_reg <= sw_reg + WIDX_W'(1);
                end
            end

            if (comb_en)
            begin
                if (comb_hit_a || comb_hit_b)
                begin
                    found_reg    <= 1'b1;
                    at_reg       <= comb_at;
                    rg_first_reg <= comb_at;
                    rg_last_reg  <= PIDX_W'(CNT_W'(comb_at) + n_reg - CNT_W'(1));
                    ptr_reg      <= comb_at[PIDX_W-1 -: WIDX_W];
                end
                else
                begin
                    miss_reg <= s4_last_reg;
                    if (s4_all_reg)
                    begin
                        run_reg <= run_reg + CNT_W'(WORD_BITS);
                    end
                    else
                    begin
                        run_reg       <= CNT_W'(s4_lead_reg);
                        run_start_reg <= CNT_W'({s4_w_reg, {BIT_W{1'b0}}})
                                       + CNT_W'(WORD_BITS) - CNT_W'(s4_lead_reg);
                    end
                end
            end

            if (cmd.op == DP_MARK_WR || cmd.op == DP_CLR_WR)
            begin
                wvalid_reg[ptr_reg] <= 1'b1;
            end
            if (cmd.op == DP_MARK_WR)
            begin
                ptr_reg <= ptr_reg + WIDX_W'(1);
            end
            if (cmd.op == DP_CLR_ACC)
            begin
                ptr_reg   <= ptr_reg + WIDX_W'(1);
                free_reg  <= free_reg + CNT_W'(pop_lo_reg) + CNT_W'(pop_hi_reg);
                freed_reg <= freed_reg + CNT_W'(pop_lo_reg) + CNT_W'(pop_hi_reg);
            end

            if (cmd.op == DP_EMIT)
            begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= '0;
                unique case (cmd.kind)
                    RES_ALLOC_OK:
                    begin
                        out_data_reg.status         <= ST_OK;
                        out_data_reg.result_address <= base_reg
                                                     + (ADDR_W'(at_reg) << PAGE_SHIFT);
                        hint_reg <= at_reg;
                        free_reg <= free_reg - n_reg;
                    end
                    RES_NO_SPACE:
                    begin
                        out_data_reg.status <= ST_NO_SPACE;
                    end
                    RES_BAD_ADDR:
                    begin
                        out_data_reg.status <= ST_BAD_ADDR;
                    end
                    RES_FREE_DONE:
                    begin
                        out_data_reg.status             <= (dup != '0) ? ST_DUP_FREE : ST_OK;
                        out_data_reg.already_free_count <= dup;
                    end
                    default:
                    begin
                        out_data_reg.status <= ST_NO_SPACE;
                    end
                endcase
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // A search ends either with a hit or with a miss, never both.
    `BPA_ASSERT(a_found_xor_miss, !(found_reg && miss_reg))
    // The free-page count never exceeds the pool size.
    `BPA_ASSERT(a_free_le_pool, free_reg <= eff_reg)
    // A new result is only written once the previous one has been transferred.
    `BPA_ASSERT_IMPLY(a_emit_no_overrun, cmd.op == DP_EMIT, !(out_valid_reg && !out_ready))

endmodule

`default_nettype wire

[rtl/bitmap_page_allocator.sv]
// Bitmap page allocator, top level: next-fit contiguous allocation over one pool.
// One request at a time; the bitmap search walks one word per cycle.
// Reset (asynchronous, active low) empties the pool and marks every page free
// at once, through per-word valid bits; no clearing pass is needed.
`default_nettype none

module bitmap_page_allocator
    import bpa_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  req_t                       in_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output rsp_t                       out_data
);

    // The controller decides the order of the phases of a request; the
    // datapath owns the bitmap, the counters and the result register.
    dp_cmd_t    cmd;
    dp_status_t status;

    // The controller accepts a request only when it is idle. The result
    // register is separate, so a finished result may wait for its transfer
    // while the next request is already being worked on.
    bpa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath searches the bitmap one 64-page word per cycle through a
    // short pipeline, then marks or clears the pages word by word with a
    // read-modify-write of the bitmap memory.
    bpa_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire
